>>> design/assert_macros.svh
// Assertion macros shared by the register port design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("implication check failed");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> design/pprf_pkg.sv
// Shared constants, codes and types of the register port and frame timing block.
package pprf_pkg;

  localparam int OBJECT_DEPTH = 256;
  localparam int OBJ_AW       = $clog2(OBJECT_DEPTH);
  localparam int LAST_DOT     = 340;
  localparam int LAST_LINE    = 261;
  localparam int VBLANK_LINE  = 241;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Item commands
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_CTRL    = 3'd0;
  localparam logic [2:0] REG_MASK    = 3'd1;
  localparam logic [2:0] REG_STATUS  = 3'd2;
  localparam logic [2:0] REG_OAMADDR = 3'd3;
  localparam logic [2:0] REG_OAMDATA = 3'd4;
  localparam logic [2:0] REG_SCROLL  = 3'd5;
  localparam logic [2:0] REG_ADDR    = 3'd6;
  localparam logic [2:0] REG_DATA    = 3'd7;

  // Video memory request codes
  localparam logic [1:0] VRAM_NONE  = 2'd0;
  localparam logic [1:0] VRAM_READ  = 2'd1;
  localparam logic [1:0] VRAM_WRITE = 2'd2;

  localparam int CTRL_INC_BIT = 2;
  localparam int CTRL_NMI_BIT = 7;
  localparam logic [7:0]  SCROLL_NEG_START = 8'd240;
  localparam logic [15:0] ADDR_STEP_ONE    = 16'd1;
  localparam logic [15:0] ADDR_STEP_WIDE   = 16'd32;

  // Classified operation carried from front to back
  typedef enum logic [3:0] {
    OP_NOP,
    OP_TICK,
    OP_RD_STATUS,
    OP_RD_OAM,
    OP_RD_DATA,
    OP_WR_CTRL,
    OP_WR_MASK,
    OP_WR_OAMADDR,
    OP_WR_OAMDATA,
    OP_WR_SCROLL,
    OP_WR_ADDR,
    OP_WR_DATA
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } entry_t;

endpackage

>>> design/pprf_ifs.sv
// Channel interfaces for incoming items and outgoing results.
interface pprf_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [2:0] reg_sel;
  logic [7:0] write_data;

  modport source (output valid, cmd, reg_sel, write_data, input ready);
  modport sink (input valid, cmd, reg_sel, write_data, output ready);
endinterface

interface pprf_result_if;
  logic              valid;
  logic              ready;
  logic [7:0]        read_data;
  logic [1:0]        vram_op;
  logic [15:0]       vram_address;
  logic [7:0]        vram_wdata;
  logic              nmi_pulse;
  logic              vblank_flag;
  logic [8:0]        scanline;
  logic [8:0]        dot;
  logic [7:0]        mask_value;
  logic [7:0]        scroll_x;
  logic signed [8:0] scroll_y;

  modport source (output valid, read_data, vram_op, vram_address, vram_wdata, nmi_pulse,
                  vblank_flag, scanline, dot, mask_value, scroll_x, scroll_y,
                  input ready);
  modport sink (input valid, read_data, vram_op, vram_address, vram_wdata, nmi_pulse,
                vblank_flag, scanline, dot, mask_value, scroll_x, scroll_y,
                output ready);
endinterface

>>> design/pprf_front.sv
// Front part: accepts items and classifies them into operations.
module pprf_front import pprf_pkg::*; (
  pprf_item_if.sink item,
  input  logic      q_full,
  output logic      push,
  output entry_t    entry
);

  op_t op;

  // Classify command and register index
  always_comb begin
    op = OP_NOP;
    case (item.cmd)
      CMD_TICK: op = OP_TICK;
      CMD_READ: begin
        case (item.reg_sel)
          REG_STATUS:  op = OP_RD_STATUS;
          REG_OAMDATA: op = OP_RD_OAM;
          REG_DATA:    op = OP_RD_DATA;
          default:     op = OP_NOP;
        endcase
      end
      CMD_WRITE: begin
        case (item.reg_sel)
          REG_CTRL:    op = OP_WR_CTRL;
          REG_MASK:    op = OP_WR_MASK;
          REG_OAMADDR: op = OP_WR_OAMADDR;
          REG_OAMDATA: op = OP_WR_OAMDATA;
          REG_SCROLL:  op = OP_WR_SCROLL;
          REG_ADDR:    op = OP_WR_ADDR;
          REG_DATA:    op = OP_WR_DATA;
          default:     op = OP_NOP;
        endcase
      end
      default: op = OP_NOP;
    endcase
  end

  // Take a request whenever the queue has room
  assign item.ready = !q_full;
  assign push       = item.valid && !q_full;
  assign entry.op   = op;
  assign entry.data = item.write_data;

endmodule

>>> design/pprf_queue.sv
// Short queue of classified operations between front and back.
module pprf_queue import pprf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   valid,
  output entry_t head
);

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/pprf_back.sv
// Back part: register file, frame timing, object store and result register.
module pprf_back import pprf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  entry_t      q_head,
  output logic        pop,
  pprf_result_if.source result
);

  localparam logic [8:0] LAST_DOT_V    = 9'(LAST_DOT);
  localparam logic [8:0] LAST_LINE_V   = 9'(LAST_LINE);
  localparam logic [8:0] VBLANK_LINE_V = 9'(VBLANK_LINE);

  // Architectural state
  logic [8:0]        dot_count, dot_count_next;
  logic [8:0]        line_count, line_count_next;
  logic              vblank, vblank_next;
  logic [7:0]        ctrl_reg, ctrl_reg_next;
  logic [7:0]        mask_reg, mask_reg_next;
  logic [OBJ_AW-1:0] object_index, object_index_next;
  logic [15:0]       video_address, video_address_next;
  logic              address_toggle, address_toggle_next;
  logic              scroll_toggle, scroll_toggle_next;
  logic [7:0]        horiz_scroll, horiz_scroll_next;
  logic [8:0]        vert_scroll, vert_scroll_next;

  logic [7:0]        obj_mem [OBJECT_DEPTH];
  logic [7:0]        obj_q;

  // Per-item result values
  logic [7:0]  rdata;
  logic        oam_rd;
  logic [1:0]  vop;
  logic [15:0] vaddr;
  logic [7:0]  vwdata;
  logic        nmi;
  logic [15:0] step;

  // Result register
  logic        res_valid;
  logic [7:0]  res_rdata;
  logic        res_oam;
  logic [1:0]  res_vop;
  logic [15:0] res_vaddr;
  logic [7:0]  res_vwdata;
  logic        res_nmi;
  logic        res_vblank;
  logic [8:0]  res_line;
  logic [8:0]  res_dot;
  logic [7:0]  res_mask;
  logic [7:0]  res_hscroll;
  logic [8:0]  res_vscroll;

  logic load;

  assign load = !res_valid || result.ready;
  assign pop  = q_valid && load;
  assign step = ctrl_reg[CTRL_INC_BIT] ? ADDR_STEP_WIDE : ADDR_STEP_ONE;

  // Execute the head operation
  always_comb begin
    dot_count_next      = dot_count;
    line_count_next     = line_count;
    vblank_next         = vblank;
    ctrl_reg_next       = ctrl_reg;
    mask_reg_next       = mask_reg;
    object_index_next   = object_index;
    video_address_next  = video_address;
    address_toggle_next = address_toggle;
    scroll_toggle_next  = scroll_toggle;
    horiz_scroll_next   = horiz_scroll;
    vert_scroll_next    = vert_scroll;
    rdata  = '0;
    oam_rd = 1'b0;
    vop    = VRAM_NONE;
    vaddr  = '0;
    vwdata = '0;
    nmi    = 1'b0;
    case (q_head.op)
      OP_TICK: begin
        if (line_count == VBLANK_LINE_V && dot_count == 9'd1) begin
          vblank_next = 1'b1;
          nmi         = ctrl_reg[CTRL_NMI_BIT];
        end
        if (line_count == LAST_LINE_V && dot_count == 9'd0) begin
          vblank_next = 1'b0;
        end
        if (dot_count == LAST_DOT_V) begin
          dot_count_next  = '0;
          line_count_next = (line_count == LAST_LINE_V) ? '0 : line_count + 9'd1;
        end else begin
          dot_count_next = dot_count + 9'd1;
        end
      end
      OP_RD_STATUS: begin
        rdata       = {vblank, 7'd0};
        vblank_next = 1'b0;
      end
      OP_RD_OAM: oam_rd = 1'b1;
      OP_RD_DATA: begin
        vop                = VRAM_READ;
        vaddr              = video_address;
        video_address_next = video_address + step;
      end
      OP_WR_CTRL:    ctrl_reg_next = q_head.data;
      OP_WR_MASK:    mask_reg_next = q_head.data;
      OP_WR_OAMADDR: object_index_next = q_head.data[OBJ_AW-1:0];
      OP_WR_SCROLL: begin
        if (!scroll_toggle) begin
          horiz_scroll_next  = q_head.data;
          scroll_toggle_next = 1'b1;
        end else begin
          vert_scroll_next   = {q_head.data >= SCROLL_NEG_START, q_head.data};
          scroll_toggle_next = 1'b0;
        end
      end
      OP_WR_ADDR: begin
        if (!address_toggle) begin
          video_address_next  = {q_head.data, video_address[7:0]};
          address_toggle_next = 1'b1;
        end else begin
          video_address_next  = {video_address[15:8], q_head.data};
          address_toggle_next = 1'b0;
        end
      end
      OP_WR_DATA: begin
        vop                = VRAM_WRITE;
        vaddr              = video_address;
        vwdata             = q_head.data;
        video_address_next = video_address + step;
      end
      default: ;
    endcase
  end

  // Commit state on each popped request
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_count      <= '0;
      line_count     <= '0;
      vblank         <= 1'b0;
      ctrl_reg       <= '0;
      mask_reg       <= '0;
      object_index   <= '0;
      video_address  <= '0;
      address_toggle <= 1'b0;
      scroll_toggle  <= 1'b0;
      horiz_scroll   <= '0;
      vert_scroll    <= '0;
    end else if (pop) begin
      dot_count      <= dot_count_next;
      line_count     <= line_count_next;
      vblank         <= vblank_next;
      ctrl_reg       <= ctrl_reg_next;
      mask_reg       <= mask_reg_next;
      object_index   <= object_index_next;
      video_address  <= video_address_next;
      address_toggle <= address_toggle_next;
      scroll_toggle  <= scroll_toggle_next;
      horiz_scroll   <= horiz_scroll_next;
      vert_scroll    <= vert_scroll_next;
    end
  end

  // Object store: write on object data write, read data held with the result
  always_ff @(posedge clk) begin
    if (pop && q_head.op == OP_WR_OAMDATA) begin
      obj_mem[object_index] <= q_head.data;
    end
    if (load) begin
      obj_q <= obj_mem[object_index];
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= q_valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_rdata   <= rdata;
      res_oam     <= oam_rd;
      res_vop     <= vop;
      res_vaddr   <= vaddr;
      res_vwdata  <= vwdata;
      res_nmi     <= nmi;
      res_vblank  <= vblank_next;
      res_line    <= line_count_next;
      res_dot     <= dot_count_next;
      res_mask    <= mask_reg_next;
      res_hscroll <= horiz_scroll_next;
      res_vscroll <= vert_scroll_next;
    end
  end

  assign result.valid        = res_valid;
  assign result.read_data    = res_oam ? obj_q : res_rdata;
  assign result.vram_op      = res_vop;
  assign result.vram_address = res_vaddr;
  assign result.vram_wdata   = res_vwdata;
  assign result.nmi_pulse    = res_nmi;
  assign result.vblank_flag  = res_vblank;
  assign result.scanline     = res_line;
  assign result.dot          = res_dot;
  assign result.mask_value   = res_mask;
  assign result.scroll_x     = res_hscroll;
  assign result.scroll_y     = $signed(res_vscroll);

endmodule

>>> design/ppu_register_port_and_frame_timing.sv
// Top level: picture processor register port and frame timing.
//
//   channel  | role    | payload
//   ---------+---------+--------------------------------------------------------
//   item     | sink    | cmd, reg_sel, write_data
//   result   | source  | read_data, vram_op, vram_address, vram_wdata, nmi_pulse,
//            |         | vblank_flag, scanline, dot, mask_value, scroll_x, scroll_y
//
// One item per clock sustained while results are taken; items pass the queue, then the result register.
// The two-entry operation queue lets the front keep taking items while a result waits.
// The back commits one operation per cycle unless the result stalls; the object store read
// is registered with it. Synchronous reset clears the counters, port registers, result valid
// flag and queue; the object store keeps whatever it holds until written.
`include "assert_macros.svh"

module ppu_register_port_and_frame_timing import pprf_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  pprf_item_if.sink     item,
  pprf_result_if.source result
);

  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   q_valid;
  logic   pop;
  entry_t q_head;

  pprf_front u_front (
    .item   (item),
    .q_full (q_full),
    .push   (push),
    .entry  (push_entry)
  );

  pprf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  pprf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (pop),
    .result  (result)
  );

  // An NMI only goes out with the vblank flag set
  `ASSERT_IMPLIES(a_nmi_with_vblank, clk, rst, result.valid && result.nmi_pulse, result.vblank_flag)
  // No video request means a zero address and data
  `ASSERT_IMPLIES(a_idle_vram_zero, clk, rst, result.valid && result.vram_op == VRAM_NONE, result.vram_address == 16'd0 && result.vram_wdata == 8'd0)
  // Counters stay in the frame
  `ASSERT_IMPLIES(a_counters_range, clk, rst, result.valid, result.dot <= 9'(LAST_DOT) && result.scanline <= 9'(LAST_LINE))
  // A popped operation always produces a result next cycle
  `ASSERT_NEXT(a_pop_gives_result, clk, rst, pop, result.valid)

endmodule

>>> tb/pprf_checker.sv
// Result checker: predicts each register port result and compares it with the block output.
module pprf_checker import pprf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  pprf_item_if   item_ch,
  pprf_result_if result_ch,
  output int     fail_count,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 100;

  typedef struct {
    logic [7:0]        read_data;
    logic [1:0]        vram_op;
    logic [15:0]       vram_address;
    logic [7:0]        vram_wdata;
    logic              nmi_pulse;
    logic              vblank_flag;
    logic [8:0]        scanline;
    logic [8:0]        dot;
    logic [7:0]        mask_value;
    logic [7:0]        scroll_x;
    logic signed [8:0] scroll_y;
  } port_result_t;

  // Predicted port and timing state
  logic [8:0]        dot_cnt;
  logic [8:0]        line_cnt;
  logic              in_vblank;
  logic [7:0]        ctrl_byte;
  logic [7:0]        mask_byte;
  logic [7:0]        obj_ptr;
  logic [7:0]        obj_mem [OBJECT_DEPTH];
  logic [15:0]       vid_addr;
  logic              addr_low_next;
  logic              scroll_y_next;
  logic [7:0]        hscroll;
  logic signed [8:0] vscroll;

  port_result_t port_results_due [$];

  // Advance the predicted state by one request and return the result it causes
  function automatic port_result_t predict_port_result(logic [1:0] cmd, logic [2:0] sel,
                                                       logic [7:0] wd);
    port_result_t r;
    logic [15:0]  step;
    r = '{default: '0};
    step = ctrl_byte[CTRL_INC_BIT] ? ADDR_STEP_WIDE : ADDR_STEP_ONE;
    case (cmd)
      CMD_TICK: begin
        if (line_cnt == VBLANK_LINE && dot_cnt == 9'd1) begin
          in_vblank = 1'b1;
          r.nmi_pulse = ctrl_byte[CTRL_NMI_BIT];
        end
        if (line_cnt == LAST_LINE && dot_cnt == 9'd0) in_vblank = 1'b0;
        if (dot_cnt == LAST_DOT) begin
          dot_cnt = '0;
          line_cnt = (line_cnt == LAST_LINE) ? 9'd0 : line_cnt + 9'd1;
        end else begin
          dot_cnt = dot_cnt + 9'd1;
        end
      end
      CMD_READ: begin
        case (sel)
          REG_STATUS: begin
            r.read_data = {in_vblank, 7'b0};
            in_vblank = 1'b0;
          end
          REG_OAMDATA: r.read_data = obj_mem[obj_ptr];
          REG_DATA: begin
            r.vram_op = VRAM_READ;
            r.vram_address = vid_addr;
            vid_addr = vid_addr + step;
          end
          default: ;
        endcase
      end
      CMD_WRITE: begin
        case (sel)
          REG_CTRL:    ctrl_byte = wd;
          REG_MASK:    mask_byte = wd;
          REG_OAMADDR: obj_ptr = wd;
          REG_OAMDATA: obj_mem[obj_ptr] = wd;
          REG_SCROLL: begin
            if (!scroll_y_next) hscroll = wd;
            else vscroll = (wd < SCROLL_NEG_START) ? {1'b0, wd} : {1'b1, wd};
            scroll_y_next = !scroll_y_next;
          end
          REG_ADDR: begin
            if (!addr_low_next) vid_addr[15:8] = wd;
            else vid_addr[7:0] = wd;
            addr_low_next = !addr_low_next;
          end
          REG_DATA: begin
            r.vram_op = VRAM_WRITE;
            r.vram_address = vid_addr;
            r.vram_wdata = wd;
            vid_addr = vid_addr + step;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.vblank_flag = in_vblank;
    r.scanline = line_cnt;
    r.dot = dot_cnt;
    r.mask_value = mask_byte;
    r.scroll_x = hscroll;
    r.scroll_y = vscroll;
    return r;
  endfunction

  task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t %s mismatch: expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  // Compare the oldest pending prediction with the result just taken
  task automatic compare_result(port_result_t want);
    check_field("read_data", 16'(want.read_data), 16'(result_ch.read_data));
    check_field("vram_op", 16'(want.vram_op), 16'(result_ch.vram_op));
    check_field("vram_address", want.vram_address, result_ch.vram_address);
    check_field("vram_wdata", 16'(want.vram_wdata), 16'(result_ch.vram_wdata));
    check_field("nmi_pulse", 16'(want.nmi_pulse), 16'(result_ch.nmi_pulse));
    check_field("vblank_flag", 16'(want.vblank_flag), 16'(result_ch.vblank_flag));
    check_field("scanline", 16'(want.scanline), 16'(result_ch.scanline));
    check_field("dot", 16'(want.dot), 16'(result_ch.dot));
    check_field("mask_value", 16'(want.mask_value), 16'(result_ch.mask_value));
    check_field("scroll_x", 16'(want.scroll_x), 16'(result_ch.scroll_x));
    check_field("scroll_y", 16'(want.scroll_y), 16'(result_ch.scroll_y));
  endtask

  // Pop and compare taken results, then predict taken requests
  always @(posedge clk) begin
    if (rst) begin
      dot_cnt = '0;
      line_cnt = '0;
      in_vblank = 1'b0;
      ctrl_byte = '0;
      mask_byte = '0;
      obj_ptr = '0;
      vid_addr = '0;
      addr_low_next = 1'b0;
      scroll_y_next = 1'b0;
      hscroll = '0;
      vscroll = '0;
      port_results_due.delete();
      pending = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (port_results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t result with nothing expected: expected none, got dot %0d line %0d",
                     $time, result_ch.dot, result_ch.scanline);
        end else begin
          compare_result(port_results_due.pop_front());
        end
      end
      if (item_ch.valid && item_ch.ready)
        port_results_due.push_back(predict_port_result(item_ch.cmd, item_ch.reg_sel,
                                                       item_ch.write_data));
      pending = port_results_due.size();
    end
  end

endmodule

>>> tb/testbench.sv
// Top of the register port testbench: clock, reset, request stimulus, handshake pacing, verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pprf_pkg::*;

  localparam int         CLK_HALF         = 10;
  localparam int         RESET_CYCLES     = 6;
  localparam int         WATCHDOG_LIMIT   = 4000;
  localparam int         RX_HOLD_CYCLES   = 150;
  localparam int         RANDOM_PER_PHASE = 580;
  localparam int         SETTLE_CYCLES    = 8;
  localparam logic [1:0] CMD_UNUSED       = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pprf_item_if   item_ch ();
  pprf_result_if result_ch ();

  int         fail_count;
  int         pending;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         hold_requests;
  int         hold_seen;
  int         hold_left;
  int         sent;
  int         idle_run;
  logic [7:0] obj_ptr;
  bit         obj_written [OBJECT_DEPTH];
  logic [2:0] write_only_regs [5] = '{REG_CTRL, REG_MASK, REG_OAMADDR, REG_SCROLL, REG_ADDR};

  ppu_register_port_and_frame_timing dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  pprf_checker port_checker (
    .clk        (clk),
    .rst        (rst),
    .item_ch    (item_ch),
    .result_ch  (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #(CLK_HALF) clk = ~clk;

  // Pace the result side; a hold request forces a long stall
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = RX_HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // End the run when no handshake completes for too long
  initial begin
    idle_run = 0;
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("testbench: errors");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one request, with random gaps, and hold it until taken
  task automatic offer_request(logic [1:0] c, logic [2:0] s, logic [7:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.cmd <= c;
    item_ch.reg_sel <= s;
    item_ch.write_data <= d;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  // Never read an object entry that was never written: turn such a read into a write
  task automatic issue(logic [1:0] c, logic [2:0] s, logic [7:0] d);
    if (c == CMD_READ && s == REG_OAMDATA && !obj_written[obj_ptr]) c = CMD_WRITE;
    if (c == CMD_WRITE && s == REG_OAMADDR) obj_ptr = d;
    if (c == CMD_WRITE && s == REG_OAMDATA) obj_written[obj_ptr] = 1'b1;
    sent++;
    offer_request(c, s, d);
  endtask

  // Stop offering until every predicted result has arrived
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One short well-formed access sequence with random content, or noise
  task automatic random_sequence();
    int n;
    case ($urandom_range(9))
      0, 1, 2: begin
        n = $urandom_range(40, 1);
        repeat (n) issue(CMD_TICK, 3'($urandom), 8'($urandom));
      end
      3: begin
        issue(CMD_WRITE, REG_ADDR, rand_byte());
        issue(CMD_WRITE, REG_ADDR, rand_byte());
        n = $urandom_range(6, 1);
        repeat (n) issue($urandom_range(1) ? CMD_WRITE : CMD_READ, REG_DATA, rand_byte());
      end
      4: begin
        issue(CMD_WRITE, REG_OAMADDR, rand_byte());
        n = $urandom_range(4, 1);
        repeat (n) issue($urandom_range(1) ? CMD_WRITE : CMD_READ, REG_OAMDATA, rand_byte());
      end
      5: begin
        issue(CMD_WRITE, REG_SCROLL, rand_byte());
        issue(CMD_WRITE, REG_SCROLL, rand_byte());
      end
      6: begin
        issue(CMD_WRITE, REG_CTRL, rand_byte());
        issue(CMD_WRITE, REG_MASK, rand_byte());
      end
      7: issue(CMD_READ, REG_STATUS, 8'($urandom));
      default: issue(2'($urandom), 3'($urandom), 8'($urandom));
    endcase
  endtask

  // One pacing phase: long result stall at the start, then random traffic
  task automatic run_phase(int s_pct, int r_pct);
    int target;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    target = sent + RANDOM_PER_PHASE;
    hold_requests++;
    while (sent < target) random_sequence();
    drain_results();
  endtask

  initial begin
    item_ch.valid = 1'b0;
    item_ch.cmd = CMD_TICK;
    item_ch.reg_sel = REG_CTRL;
    item_ch.write_data = 8'h00;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = 0;
    hold_seen = 0;
    hold_left = 0;
    sent = 0;
    obj_ptr = 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every register, scroll sign, address wrap, odd commands
    issue(CMD_READ, REG_STATUS, 8'h00);
    issue(CMD_WRITE, REG_CTRL, 8'h00);
    issue(CMD_WRITE, REG_MASK, 8'hFF);
    issue(CMD_WRITE, REG_MASK, 8'h00);
    issue(CMD_WRITE, REG_OAMADDR, 8'hFF);
    issue(CMD_WRITE, REG_OAMDATA, 8'hA5);
    issue(CMD_READ, REG_OAMDATA, 8'hFF);
    issue(CMD_WRITE, REG_SCROLL, 8'hFF);
    issue(CMD_WRITE, REG_SCROLL, 8'hF0);
    issue(CMD_WRITE, REG_SCROLL, 8'h00);
    issue(CMD_WRITE, REG_SCROLL, 8'hEF);
    issue(CMD_WRITE, REG_ADDR, 8'hFF);
    issue(CMD_WRITE, REG_ADDR, 8'hFF);
    issue(CMD_WRITE, REG_DATA, 8'h5A);
    issue(CMD_WRITE, REG_CTRL, 8'h04);
    issue(CMD_WRITE, REG_ADDR, 8'hFF);
    issue(CMD_WRITE, REG_ADDR, 8'hF0);
    issue(CMD_READ, REG_DATA, 8'h00);
    issue(CMD_WRITE, REG_STATUS, 8'hFF);
    issue(CMD_UNUSED, REG_DATA, 8'hFF);
    foreach (write_only_regs[k]) issue(CMD_READ, write_only_regs[k], 8'h00);
    issue(CMD_TICK, REG_DATA, 8'hFF);
    drain_results();

    run_phase(32, 48);
    run_phase(48, 32);
    run_phase(0, 0);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
